@@ design/llctg_pkg.sv @@
`timescale 1ns / 1ps

package llctg_pkg;

    localparam int CORES   = 4;
    localparam int THREADS = 64;

    localparam int CORE_W = $clog2(CORES);
    localparam int TID_W  = 6;
    localparam int TIDX_W = $clog2(THREADS);
    localparam int LOAD_W = $clog2(THREADS + 1);
    localparam int CMD_W  = 3;
    localparam int CNT_W  = 32;
    localparam int ADDR_W = 64;
    localparam int REG_W  = 64;
    localparam int STAT_W = 2;
    localparam int CIDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_START = 3'd0;
    localparam logic [CMD_W-1:0] CMD_END   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_LIVE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_ALREADY_LIVE = 2'd2;
    localparam logic [STAT_W-1:0] ST_HALTED       = 2'd3;

    localparam logic [CIDX_W-1:0] REG_WINDOW_START  = 1'd0;
    localparam logic [CIDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

    localparam logic [REG_W-1:0] WINDOW_START_RST  = 64'd100000000;
    localparam logic [REG_W-1:0] WINDOW_LENGTH_RST = 64'd10000000;

    // Saturating 64-bit add.
    function automatic logic [REG_W-1:0] sat_add(input logic [REG_W-1:0] a,
                                                 input logic [REG_W-1:0] b);
        logic [REG_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[REG_W] ? {REG_W{1'b1}} : s[REG_W-1:0];
    endfunction

endpackage

@@ design/llctg_if.sv @@
`timescale 1ns / 1ps

interface llctg_evt_if;
    import llctg_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [TID_W-1:0]  thread_id;
    logic [CNT_W-1:0]  insn_count;
    logic [ADDR_W-1:0] access_addr;

    modport source (output valid, cmd, thread_id, insn_count, access_addr, input ready);
    modport sink   (input valid, cmd, thread_id, insn_count, access_addr, output ready);
endinterface

interface llctg_res_if;
    import llctg_pkg::*;

    logic              valid;
    logic              ready;
    logic [CORE_W-1:0] core;
    logic              record_valid;
    logic              is_store;
    logic [ADDR_W-1:0] record_addr;
    logic              stop_reached;
    logic [STAT_W-1:0] status;

    modport source (output valid, core, record_valid, is_store, record_addr, stop_reached,
                    status, input ready);
    modport sink   (input valid, core, record_valid, is_store, record_addr, stop_reached,
                    status, output ready);
endinterface

@@ design/llctg_ram.sv @@
`timescale 1ns / 1ps

module llctg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/least_loaded_core_trace_gate.sv @@
`timescale 1ns / 1ps

// Thread-to-core placement and memory-access trace gate. Each event transfer
// is handled in an accept cycle, which reads the thread's core from the
// thread-core memory, and then an execute cycle, which places, frees or looks
// up the thread, updates the per-core live counts and the instruction total,
// and loads the result into the output register. A new event is taken once
// the previous one has left the execute cycle, so events do not overlap; a
// result that is not taken holds the execute cycle. Starts go to the core
// with the fewest live threads (lowest index on a tie). Reads and writes by
// live threads yield a trace record once the instruction total is above
// window_start. When the total passes window_start + window_length
// (saturating), stop is reported and every later event answers "halted".
// Registers take writes at any time the block is idle; no clearing pass.

module least_loaded_core_trace_gate (
    input  logic                         clk,
    input  logic                         rst_n,
    llctg_evt_if.sink                    evt,
    llctg_res_if.source                  res,
    input  logic                         cfg_we,
    input  logic [llctg_pkg::CIDX_W-1:0] cfg_index,
    input  logic [llctg_pkg::REG_W-1:0]  cfg_data
);
    import llctg_pkg::*;

    localparam logic [TID_W:0] THREADS_LIM = (TID_W + 1)'(THREADS);

    // configuration
    logic [REG_W-1:0] wstart_reg;
    logic [REG_W-1:0] wlen_reg;

    // block state
    logic [THREADS-1:0] live_reg;
    logic [THREADS-1:0] live_next;
    logic [LOAD_W-1:0]  load_reg [CORES];
    logic [LOAD_W-1:0]  load_next [CORES];
    logic [REG_W-1:0]   total_reg;
    logic [REG_W-1:0]   total_next;
    logic               halted_reg;
    logic               halted_next;

    // captured event
    logic               busy_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [TID_W-1:0]   tid_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [REG_W-1:0]   sum_reg;

    // output register
    logic               ovalid_reg;
    logic [CORE_W-1:0]  core_reg;
    logic               rvalid_reg;
    logic               store_reg;
    logic [ADDR_W-1:0]  raddr_reg;
    logic               stop_reg;
    logic [STAT_W-1:0]  status_reg;

    logic [CORE_W-1:0]  core_next;
    logic               rvalid_next;
    logic               store_next;
    logic [ADDR_W-1:0]  raddr_next;
    logic               stop_next;
    logic [STAT_W-1:0]  status_next;

    logic               accept;
    logic               exec;
    logic               out_free;
    logic               in_range;
    logic [TIDX_W-1:0]  tidx;
    logic               live;
    logic [CORE_W-1:0]  mem_core;
    logic [CORE_W-1:0]  best;
    logic               mem_we;
    logic [REG_W-1:0]   window_end;

    assign accept   = evt.valid && evt.ready;
    assign out_free = !ovalid_reg || res.ready;
    assign exec     = busy_reg && out_free;
    assign evt.ready = !busy_reg;

    assign in_range = {1'b0, tid_reg} < THREADS_LIM;
    assign tidx     = tid_reg[TIDX_W-1:0];
    assign live     = in_range && live_reg[tidx];

    // Thread-core memory: read on transfer, written when a thread is placed.
    llctg_ram #(
        .WIDTH (CORE_W),
        .DEPTH (THREADS)
    ) u_core_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (tidx),
        .wdata (best),
        .re    (accept),
        .raddr (evt.thread_id[TIDX_W-1:0]),
        .rdata (mem_core)
    );

    // least-loaded core, lowest index wins ties
    always_comb
    begin
        best = '0;
        for (int i = 1; i < CORES; i++)
        begin
            if (load_reg[i] < load_reg[best])
            begin
                best = CORE_W'(i);
            end
        end
    end

    assign window_end = sat_add(wstart_reg, wlen_reg);

    always_comb
    begin
        live_next   = live_reg;
        load_next   = load_reg;
        total_next  = total_reg;
        halted_next = halted_reg;
        mem_we      = 1'b0;
        core_next   = '0;
        rvalid_next = 1'b0;
        store_next  = 1'b0;
        raddr_next  = '0;
        stop_next   = 1'b0;
        status_next = ST_OK;

        if (halted_reg)
        begin
            stop_next   = 1'b1;
            status_next = ST_HALTED;
        end
        else
        begin
            case (cmd_reg)
                CMD_START:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_NOT_LIVE;
                    end
                    else if (live)
                    begin
                        status_next = ST_ALREADY_LIVE;
                        core_next   = mem_core;
                    end
                    else
                    begin
                        mem_we          = exec;
                        live_next[tidx] = 1'b1;
                        load_next[best] = load_reg[best] + LOAD_W'(1);
                        core_next       = best;
                    end
                end
                CMD_END:
                begin
                    if (!live)
                    begin
                        status_next = ST_NOT_LIVE;
                    end
                    else
                    begin
                        live_next[tidx] = 1'b0;
                        if (load_reg[mem_core] != '0)
                        begin
                            load_next[mem_core] = load_reg[mem_core] - LOAD_W'(1);
                        end
                    end
                end
                CMD_COUNT:
                begin
                    total_next = sum_reg;
                    if (sum_reg > window_end)
                    begin
                        halted_next = 1'b1;
                        stop_next   = 1'b1;
                    end
                end
                CMD_READ, CMD_WRITE:
                begin
                    if (!live)
                    begin
                        status_next = ST_NOT_LIVE;
                    end
                    else if (total_reg > wstart_reg)
                    begin
                        rvalid_next = 1'b1;
                        core_next   = mem_core;
                        store_next  = (cmd_reg == CMD_WRITE);
                        raddr_next  = addr_reg;
                    end
                end
                default:
                begin
                    // unknown command: ignored
                end
            endcase
        end
    end

    // control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wstart_reg <= WINDOW_START_RST;
            wlen_reg   <= WINDOW_LENGTH_RST;
            live_reg   <= '0;
            for (int i = 0; i < CORES; i++)
            begin
                load_reg[i] <= '0;
            end
            total_reg  <= '0;
            halted_reg <= 1'b0;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_START:  wstart_reg <= cfg_data;
                    REG_WINDOW_LENGTH: wlen_reg   <= cfg_data;
                    default:           ;
                endcase
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (exec)
            begin
                busy_reg <= 1'b0;
            end
            if (exec)
            begin
                live_reg   <= live_next;
                load_reg   <= load_next;
                total_reg  <= total_next;
                halted_reg <= halted_next;
                ovalid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= evt.cmd;
            tid_reg  <= evt.thread_id;
            addr_reg <= evt.access_addr;
            sum_reg  <= sat_add(total_reg, REG_W'(evt.insn_count));
        end
        if (exec)
        begin
            core_reg   <= core_next;
            rvalid_reg <= rvalid_next;
            store_reg  <= store_next;
            raddr_reg  <= raddr_next;
            stop_reg   <= stop_next;
            status_reg <= status_next;
        end
    end

    assign res.valid        = ovalid_reg;
    assign res.core         = core_reg;
    assign res.record_valid = rvalid_reg;
    assign res.is_store     = store_reg;
    assign res.record_addr  = raddr_reg;
    assign res.stop_reached = stop_reg;
    assign res.status       = status_reg;

    // live-thread bookkeeping check
    logic [LOAD_W+CORE_W-1:0] load_sum;
    always_comb
    begin
        load_sum = '0;
        for (int i = 0; i < CORES; i++)
        begin
            load_sum = load_sum + (LOAD_W + CORE_W)'(load_reg[i]);
        end
    end

    logic start_ok;
    assign start_ok = exec && !halted_reg && cmd_reg == CMD_START && in_range && !live;

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag dropped");

    a_load_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (LOAD_W + CORE_W)'($countones(live_reg)) == load_sum)
        else $error("core loads disagree with live threads");

    a_start_live: assert property (@(posedge clk) disable iff (!rst_n)
        start_ok |=> live_reg[$past(tidx)])
        else $error("placed thread not live");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        exec && !res.ready && ovalid_reg |-> 1'b0)
        else $error("result overwritten before transfer");

endmodule
